>>> src/xsfb_pkg.sv
`default_nettype none
package xsfb_pkg;

    localparam int SCREEN_COLUMNS  = 64;
    localparam int SCREEN_ROWS     = 32;
    localparam int MAX_SPRITE_ROWS = 16;
    localparam int SPRITE_WIDTH    = 8;

    localparam int COL_W = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W = $clog2(SCREEN_ROWS);

    // function codes on the input channel
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SPRITE = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef logic [SCREEN_COLUMNS-1:0] row_word_t;
    typedef logic [ROW_W-1:0]          row_addr_t;
    typedef logic [COL_W-1:0]          col_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // requests from the sequencer to the row store
    typedef struct packed {
        logic      rd_en;
        row_addr_t rd_addr;
        logic      wr_en;
        row_addr_t wr_addr;
        row_word_t wr_data;
        logic      clr;
    } store_req_t;

    // place an 8-pixel sprite row across a 64-bit row word, wrapping at the edge
    function automatic row_word_t sprite_mask(col_t x, logic [SPRITE_WIDTH-1:0] bits);
        row_word_t m;
        col_t      c;
        m = '0;
        for (int j = 0; j < SPRITE_WIDTH; j++) begin
            c = x + col_t'(j);
            if (bits[SPRITE_WIDTH-1-j]) begin
                m[c] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> src/xsfb_store.sv
`default_nettype none
module xsfb_store (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire xsfb_pkg::store_req_t req,
    output logic [xsfb_pkg::SCREEN_COLUMNS-1:0] rd_data
);

    xsfb_pkg::row_word_t             mem [xsfb_pkg::SCREEN_ROWS];
    logic [xsfb_pkg::SCREEN_ROWS-1:0] valid_reg;
    xsfb_pkg::row_word_t             rd_data_reg;

    // written rows only; an unwritten or cleared row reads as zero
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clr) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> src/xor_sprite_framebuffer.sv
`default_nettype none
// An accepted item is registered and its row read is issued; the execute state
// then writes the row word back and loads any result into the output register.
// Execute waits while a result still waits in the m_ register; no new item is
// accepted until execute is done. Clear drops all 32 row valid bits at once.
// Reset (aresetn low, synchronous) empties the store, the collision flag
// and the output register.
module xor_sprite_framebuffer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_x_pos,
    input  wire logic [7:0]  s_y_pos,
    input  wire logic [3:0]  s_row_index,
    input  wire logic [7:0]  s_row_bits,
    input  wire logic        s_last_row,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_collision,
    output logic [63:0]      m_row_pixels,
    output logic [1:0]       m_kind
);

    xsfb_pkg::state_t     state_reg, state_next;
    xsfb_pkg::store_req_t req;
    xsfb_pkg::row_word_t  rd_data;

    // item held for the execute cycle
    logic [1:0]          func_reg;
    xsfb_pkg::col_t      x_reg;
    logic [7:0]          bits_reg;
    logic                last_reg;
    logic                in_range_reg;
    xsfb_pkg::row_addr_t addr_reg;

    logic coll_reg, coll_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_collision_reg, m_collision_next;
    xsfb_pkg::row_word_t m_row_pixels_reg, m_row_pixels_next;
    logic [1:0]          m_kind_reg, m_kind_next;

    logic                accept;
    logic                need_out;
    logic                go;
    logic                hit;
    xsfb_pkg::row_word_t mask;
    xsfb_pkg::row_addr_t s_addr;

    xsfb_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == xsfb_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // draw row sits at (y + index) mod 32; read uses y mod 32
    always_comb begin
        if (s_func == xsfb_pkg::FUNC_DRAW) begin
            s_addr = s_y_pos[xsfb_pkg::ROW_W-1:0]
                   + xsfb_pkg::row_addr_t'(s_row_index);
        end else begin
            s_addr = s_y_pos[xsfb_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            x_reg        <= s_x_pos[xsfb_pkg::COL_W-1:0];
            bits_reg     <= s_row_bits;
            last_reg     <= s_last_row;
            in_range_reg <= (int'(s_row_index) < xsfb_pkg::MAX_SPRITE_ROWS);
            addr_reg     <= s_addr;
        end
    end

    assign mask = xsfb_pkg::sprite_mask(x_reg, bits_reg);
    assign hit  = in_range_reg && ((rd_data & mask) != '0);

    always_comb begin
        unique case (func_reg)
            xsfb_pkg::FUNC_DRAW:  need_out = last_reg;
            xsfb_pkg::FUNC_CLEAR: need_out = 1'b1;
            xsfb_pkg::FUNC_READ:  need_out = 1'b1;
            default:              need_out = 1'b0;
        endcase
    end

    // hold the execute step while the previous result has not been taken
    assign go = !need_out || !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        req.rd_en         = 1'b0;
        req.rd_addr       = s_addr;
        req.wr_en         = 1'b0;
        req.wr_addr       = addr_reg;
        req.wr_data       = rd_data ^ mask;
        req.clr           = 1'b0;
        coll_next         = coll_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_collision_next  = m_collision_reg;
        m_row_pixels_next = m_row_pixels_reg;
        m_kind_next       = m_kind_reg;

        unique case (state_reg)
            xsfb_pkg::ST_IDLE: begin
                if (accept) begin
                    req.rd_en  = 1'b1;
                    state_next = xsfb_pkg::ST_EXEC;
                end
            end
            xsfb_pkg::ST_EXEC: begin
                if (go) begin
                    state_next = xsfb_pkg::ST_IDLE;
                    unique case (func_reg)
                        xsfb_pkg::FUNC_DRAW: begin
                            req.wr_en = in_range_reg;
                            if (last_reg) begin
                                coll_next         = 1'b0;
                                m_valid_next      = 1'b1;
                                m_collision_next  = coll_reg || hit;
                                m_row_pixels_next = '0;
                                m_kind_next       = xsfb_pkg::KIND_SPRITE;
                            end else begin
                                coll_next = coll_reg || hit;
                            end
                        end
                        xsfb_pkg::FUNC_CLEAR: begin
                            req.clr           = 1'b1;
                            coll_next         = 1'b0;
                            m_valid_next      = 1'b1;
                            m_collision_next  = 1'b0;
                            m_row_pixels_next = '0;
                            m_kind_next       = xsfb_pkg::KIND_CLEAR;
                        end
                        xsfb_pkg::FUNC_READ: begin
                            m_valid_next      = 1'b1;
                            m_collision_next  = 1'b0;
                            m_row_pixels_next = rd_data;
                            m_kind_next       = xsfb_pkg::KIND_READ;
                        end
                        default: begin
                            // unused code: dropped silently
                        end
                    endcase
                end
            end
            default: begin
                state_next = xsfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xsfb_pkg::ST_IDLE;
            coll_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            coll_reg    <= coll_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_collision_reg  <= m_collision_next;
        m_row_pixels_reg <= m_row_pixels_next;
        m_kind_reg       <= m_kind_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_collision  = m_collision_reg;
    assign m_row_pixels = m_row_pixels_reg;
    assign m_kind       = m_kind_reg;

endmodule
`default_nettype wire

>>> dv/tb_xor_sprite_framebuffer.sv
`timescale 1ns / 100ps

module tb_xor_sprite_framebuffer;

    // func code 3 has no meaning to the block: it must vanish without a result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // items needed in total before the random phase stops
    localparam int ITEM_TARGET = 520;
    // bound on waiting for the result queue to empty
    localparam int DRAIN_LIMIT = 5000;
    // how many mismatches get a full printout
    localparam int REPORT_LIMIT = 10;

    // one result item as it should appear on the m_ side
    typedef struct packed {
        logic                collision;
        xsfb_pkg::row_word_t row_pixels;
        logic [1:0]          kind;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [7:0]  s_x_pos;
    logic [7:0]  s_y_pos;
    logic [3:0]  s_row_index;
    logic [7:0]  s_row_bits;
    logic        s_last_row;
    logic        m_valid;
    logic        m_ready;
    logic        m_collision;
    logic [63:0] m_row_pixels;
    logic [1:0]  m_kind;

    // shadow copy of the block's state, updated on every accepted item
    xsfb_pkg::row_word_t frame_shadow [xsfb_pkg::SCREEN_ROWS];
    logic                sprite_hit_seen;
    frame_result_t       pending_results [$];

    int          mismatch_count;
    int          items_sent;
    // idling controls, changed by the tests to give stretches with and without gaps
    bit          sender_gaps;
    bit          sink_stalls;
    // non-zero asks the sink process for one long hold-off of that many cycles
    int unsigned hold_off_cycles;

    xor_sprite_framebuffer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_x_pos      (s_x_pos),
        .s_y_pos      (s_y_pos),
        .s_row_index  (s_row_index),
        .s_row_bits   (s_row_bits),
        .s_last_row   (s_last_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_collision  (m_collision),
        .m_row_pixels (m_row_pixels),
        .m_kind       (m_kind)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // idle length: drawn from three ranges, the longest one now and then
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        else if (pick < 95)
            return $urandom_range(3, 6);
        return $urandom_range(15, 60);
    endfunction

    // Predictor: applies one accepted item to the shadow state and queues the
    // result it should cause. Bit 7 of the row pattern lands on column x,
    // bit 0 on column x+7, both wrapping at the screen edge.
    task automatic predict_frame_op(input logic [1:0] func, input logic [7:0] x,
                                    input logic [7:0] y, input logic [3:0] idx,
                                    input logic [7:0] bits, input logic last);
        xsfb_pkg::row_word_t word;
        xsfb_pkg::row_addr_t r;
        xsfb_pkg::col_t      c;
        frame_result_t       res;
        res.collision  = 1'b0;
        res.row_pixels = '0;
        case (func)
            xsfb_pkg::FUNC_DRAW: begin
                if (int'(idx) < xsfb_pkg::MAX_SPRITE_ROWS) begin
                    r    = xsfb_pkg::row_addr_t'(y) + xsfb_pkg::row_addr_t'(idx);
                    word = frame_shadow[r];
                    for (int j = 0; j < xsfb_pkg::SPRITE_WIDTH; j++) begin
                        if (bits[xsfb_pkg::SPRITE_WIDTH-1-j]) begin
                            c = xsfb_pkg::col_t'(x) + xsfb_pkg::col_t'(j);
                            if (word[c])
                                sprite_hit_seen = 1'b1;
                            word[c] = ~word[c];
                        end
                    end
                    frame_shadow[r] = word;
                end
                // only the final row reports, and the flag starts afresh
                if (last) begin
                    res.collision = sprite_hit_seen;
                    res.kind      = xsfb_pkg::KIND_SPRITE;
                    pending_results.push_back(res);
                    sprite_hit_seen = 1'b0;
                end
            end
            xsfb_pkg::FUNC_CLEAR: begin
                // a sprite in progress loses its collision flag too
                foreach (frame_shadow[i])
                    frame_shadow[i] = '0;
                sprite_hit_seen = 1'b0;
                res.kind = xsfb_pkg::KIND_CLEAR;
                pending_results.push_back(res);
            end
            xsfb_pkg::FUNC_READ: begin
                res.row_pixels = frame_shadow[xsfb_pkg::row_addr_t'(y)];
                res.kind       = xsfb_pkg::KIND_READ;
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Scoreboard: samples both handshakes at the rising edge, with values from
    // before the edge. The result is checked before the accepted input is
    // predicted, so a stray result can never consume a fresh expectation.
    always @(posedge aclk) begin : frame_scoreboard
        frame_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result kind", 64'(xsfb_pkg::KIND_SPRITE),
                                    64'(m_kind));
                end else begin
                    want = pending_results.pop_front();
                    if (m_kind !== want.kind)
                        report_mismatch("kind", 64'(want.kind), 64'(m_kind));
                    if (m_collision !== want.collision)
                        report_mismatch("collision", 64'(want.collision), 64'(m_collision));
                    if (m_row_pixels !== want.row_pixels)
                        report_mismatch("row_pixels", want.row_pixels, m_row_pixels);
                end
            end
            if (s_valid && s_ready)
                predict_frame_op(s_func, s_x_pos, s_y_pos, s_row_index, s_row_bits,
                                 s_last_row);
        end
    end

    // Result sink: random stalls, plus the long hold-off on request.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_n;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                hold_n          = hold_off_cycles;
                hold_off_cycles = 0;
                stall_left      = 0;
                m_ready <= 1'b0;
                repeat (hold_n - 1) @(posedge aclk);
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until the block takes it. Any idle gap comes
    // first, so valid is never dropped and raised again in one time step.
    task automatic send_item(input logic [1:0] func, input logic [7:0] x,
                             input logic [7:0] y, input logic [3:0] idx,
                             input logic [7:0] bits, input logic last);
        int unsigned gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 99) < 35)
            gap = idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_x_pos     <= x;
        s_y_pos     <= y;
        s_row_index <= idx;
        s_row_bits  <= bits;
        s_last_row  <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        if (func != FUNC_UNUSED)
            items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_results.size() != 0; k++)
            @(posedge aclk);
        // a draw without last_row may still be in flight
        repeat (4) @(posedge aclk);
    endtask

    // one well-formed sprite: rows 0..n-1, last_row on the final one
    task automatic draw_sprite(input logic [7:0] x, input logic [7:0] y,
                               input int unsigned rows);
        for (int i = 0; i < rows; i++)
            send_item(xsfb_pkg::FUNC_DRAW, x, y, 4'(i), 8'($urandom), i == rows - 1);
    endtask

    // Hand-picked items: edge wrap, collisions mid-sprite, empty patterns,
    // clear during a sprite, ignored fields and the unused func code.
    task automatic test_directed();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_item(xsfb_pkg::FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b1);
        send_item(xsfb_pkg::FUNC_READ,  8'hFF, 8'h20, 4'hF, 8'hFF, 1'b1);
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'h00, 4'h0, 8'h80, 1'b1);
        // right edge wrap on the bottom row
        send_item(xsfb_pkg::FUNC_DRAW,  8'd60, 8'd31, 4'h0, 8'hFF, 1'b0);
        // column 255 -> 63 and row 255+15 -> 14, both wrapping
        send_item(xsfb_pkg::FUNC_DRAW,  8'hFF, 8'hFF, 4'hF, 8'hAA, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'hFF, 8'hFF, 4'hF, 8'hAA, 1'b1);
        send_item(xsfb_pkg::FUNC_READ,  8'h00, 8'hFF, 4'h0, 8'h00, 1'b0);
        send_item(xsfb_pkg::FUNC_READ,  8'h55, 8'd46, 4'h5, 8'h55, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'd10, 4'h0, 8'h00, 1'b1);
        send_item(FUNC_UNUSED,          8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        // collision on a middle row must survive to the last row
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'h00, 4'h1, 8'hFF, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'h00, 4'h1, 8'h0F, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'h00, 8'h00, 4'h2, 8'h01, 1'b1);
        // clear part-way through a sprite drops its flag
        send_item(xsfb_pkg::FUNC_DRAW,  8'd5,  8'd5,  4'h0, 8'hFF, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'd5,  8'd5,  4'h0, 8'hFF, 1'b0);
        send_item(xsfb_pkg::FUNC_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        send_item(xsfb_pkg::FUNC_DRAW,  8'd5,  8'd5,  4'h0, 8'hFF, 1'b1);
        send_item(xsfb_pkg::FUNC_READ,  8'h00, 8'd5,  4'h0, 8'h00, 1'b0);
        send_item(xsfb_pkg::FUNC_DRAW,  8'hFF, 8'h00, 4'hF, 8'hFF, 1'b1);
        send_item(xsfb_pkg::FUNC_READ,  8'h00, 8'd15, 4'h0, 8'h00, 1'b0);
        send_item(xsfb_pkg::FUNC_CLEAR, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(xsfb_pkg::FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering: the output
    // register fills and the input side has to stall.
    task automatic test_backpressure();
        sender_gaps     = 1'b0;
        sink_stalls     = 1'b1;
        hold_off_cycles = 300;
        for (int i = 0; i < 36; i++) begin
            if (i % 3 == 2)
                send_item(xsfb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            else
                draw_sprite(8'($urandom), 8'($urandom), 1);
        end
        wait_drained();
    endtask

    // Mostly well-formed sprites with random content and reads to look at the
    // result; the rest is clears, broken sprites and raw noise.
    task automatic test_random_mix();
        int unsigned pick;
        int unsigned rows;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                sender_gaps = $urandom_range(0, 2) != 0;
                sink_stalls = $urandom_range(0, 2) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                rows = ($urandom_range(0, 9) == 0) ? xsfb_pkg::MAX_SPRITE_ROWS
                                                   : $urandom_range(1, 6);
                draw_sprite(8'($urandom), 8'($urandom), rows);
            end else if (pick < 80) begin
                send_item(xsfb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 83) begin
                send_item(xsfb_pkg::FUNC_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 88) begin
                // broken sprite: indices and last_row out of order
                rows = $urandom_range(1, 5);
                for (int i = 0; i < rows; i++)
                    send_item(xsfb_pkg::FUNC_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                              8'($urandom), $urandom_range(0, 3) == 0);
            end else if (pick < 95) begin
                send_item(2'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            end else begin
                // sender pause: everything has to come back first
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // Run limit, well above the slowest legal run
    initial begin
        #(2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_func          <= xsfb_pkg::FUNC_DRAW;
        s_x_pos         <= '0;
        s_y_pos         <= '0;
        s_row_index     <= '0;
        s_row_bits      <= '0;
        s_last_row      <= 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        sender_gaps     = 1'b0;
        sink_stalls     = 1'b0;
        hold_off_cycles = 0;
        sprite_hit_seen = 1'b0;
        foreach (frame_shadow[i])
            frame_shadow[i] = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_mix();

        // whatever is still queued never arrived
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
